/* sv/lzbd_pkg.sv */
`timescale 1ns / 1ps

package lzbd_pkg;

    localparam int DefHistoryDepth  = 4096;
    localparam int DefCountBits     = 24;
    localparam int DefBytesPerResult = 4;

    localparam int Slots      = 4;
    localparam int FieldWidth = 24;
    localparam int TdataWidth = 88;

    localparam logic [2:0] PH_BIT0 = 3'd0;
    localparam logic [2:0] PH_BIT1 = 3'd1;
    localparam logic [2:0] PH_SBIT = 3'd2;
    localparam logic [2:0] PH_LIT  = 3'd3;
    localparam logic [2:0] PH_SOFF = 3'd4;
    localparam logic [2:0] PH_LHI  = 3'd5;
    localparam logic [2:0] PH_LLO  = 3'd6;
    localparam logic [2:0] PH_LLEN = 3'd7;

    localparam logic [1:0] ST_IN   = 2'd0;
    localparam logic [1:0] ST_RD   = 2'd1;
    localparam logic [1:0] ST_WR   = 2'd2;
    localparam logic [1:0] ST_EMIT = 2'd3;

    typedef struct packed {
        logic [2:0] phase;
        logic [7:0] cmd;
        logic [3:0] bits;
        logic [8:0] mlen;
    } parse_t;

    function automatic parse_t drain_bits(input parse_t p);
        parse_t q;
        logic   b;
        q = p;
        for (int i = 0; i < 8; i++)
        begin
            if (q.phase <= PH_SBIT && q.bits != 4'd0)
            begin
                b      = q.cmd[0];
                q.cmd  = {1'b0, q.cmd[7:1]};
                q.bits = q.bits - 4'd1;
                if (q.phase == PH_BIT0)
                begin
                    q.phase = b ? PH_BIT1 : PH_LIT;
                end
                else if (q.phase == PH_BIT1)
                begin
                    q.mlen  = 9'd0;
                    q.phase = b ? PH_SBIT : PH_LHI;
                end
                else if (q.mlen == 9'd0)
                begin
                    q.mlen = b ? 9'd4 : 9'd2;
                end
                else
                begin
                    q.mlen  = q.mlen + {8'd0, b};
                    q.phase = PH_SOFF;
                end
            end
        end
        return q;
    endfunction

endpackage

/* sv/lz_bitflag_decompressor.sv */
`timescale 1ns / 1ps

// LZSS stream decoder with a 4096-byte history. One compressed byte is taken
// per request on the s_ side; command bytes and the first byte of a long match
// word give no result. A literal gives one result; a match of length L gives
// ceil(L/4) results, the last one with tlast set. Each decoded byte passes
// through a ring read state and then a ring write state, as the history read
// is registered; each result adds a hand-over state, which waits while the
// m_ side holds off. Input is refused while a match or literal is being
// copied. A zero long-match word ends the stream: one result with tuser set
// carries the counts, and the decoder starts afresh; history never written
// reads as zero, with no clearing pass.
module lz_bitflag_decompressor
    import lzbd_pkg::*;
#(
    parameter int HISTORY_DEPTH    = DefHistoryDepth,
    parameter int COUNT_BITS       = DefCountBits,
    parameter int BYTES_PER_RESULT = DefBytesPerResult
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,   // in_byte
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // out_byte0, out_byte1, out_byte2, out_byte3, out_count, in_consumed, out_total
    output logic [TdataWidth-1:0] m_tdata,
    output logic                  m_tlast,   // run_last
    output logic                  m_tuser    // stream_end
);

    localparam int AW    = $clog2(HISTORY_DEPTH);
    localparam int Chunk = (BYTES_PER_RESULT < Slots) ? BYTES_PER_RESULT : Slots;
    localparam logic [COUNT_BITS-1:0] CountMax = '1;

    logic [7:0] ring_mem [HISTORY_DEPTH];
    logic [7:0] rd_q;

    logic [1:0]            state_reg, state_next;
    parse_t                parse_reg, parse_next;
    logic [7:0]            held_reg, held_next;
    logic [COUNT_BITS-1:0] cons_reg, cons_next;
    logic [COUNT_BITS-1:0] prod_reg, prod_next;
    logic [AW-1:0]         wp_reg, wp_next;
    logic                  wrap_reg, wrap_next;
    logic [11:0]           off_reg, off_next;
    logic [8:0]            rem_reg, rem_next;
    logic                  lit_reg, lit_next;
    logic [7:0]            litb_reg, litb_next;
    logic                  zero_reg, zero_next;
    logic [7:0]            acc_reg [Slots];
    logic [7:0]            acc_next [Slots];
    logic [2:0]            fill_reg, fill_next;
    logic                  end_reg, end_next;
    logic [FieldWidth-1:0] econs_reg, econs_next;
    logic [FieldWidth-1:0] etot_reg, etot_next;

    logic                  mv_reg, mv_next;
    logic [TdataWidth-1:0] md_reg, md_next;
    logic                  ml_reg, ml_next;
    logic                  mu_reg, mu_next;

    logic                  accept;
    logic [AW-1:0]         off_ext;
    logic [AW-1:0]         rd_addr;
    logic [7:0]            cur_byte;
    logic                  we;
    parse_t                pre, post;
    logic [15:0]           word;
    logic [COUNT_BITS:0]   sum1, sum2, sum_tot;
    logic [31:0]           cons32, tot32;

    assign s_tready = (state_reg == ST_IN);
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = mv_reg;
    assign m_tdata  = md_reg;
    assign m_tlast  = ml_reg;
    assign m_tuser  = mu_reg;

    assign off_ext  = AW'(off_reg);
    assign rd_addr  = wp_reg - off_ext;
    assign cur_byte = lit_reg ? litb_reg : (zero_reg ? 8'd0 : rd_q);
    assign we       = (state_reg == ST_WR);
    assign word     = {held_reg, s_tdata};
    assign sum1     = {1'b0, cons_reg} + (COUNT_BITS+1)'(1);
    assign sum2     = {1'b0, cons_reg} + (COUNT_BITS+1)'(2);
    assign sum_tot  = {1'b0, prod_reg} + (COUNT_BITS+1)'(2);
    assign cons32   = 32'(cons_reg);
    assign tot32    = sum_tot[COUNT_BITS] ? 32'(CountMax) : 32'(sum_tot[COUNT_BITS-1:0]);

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            ring_mem[wp_reg] <= cur_byte;
        end
        rd_q <= ring_mem[rd_addr];
    end

    always_comb
    begin
        state_next = state_reg;
        parse_next = parse_reg;
        held_next  = held_reg;
        cons_next  = cons_reg;
        prod_next  = prod_reg;
        wp_next    = wp_reg;
        wrap_next  = wrap_reg;
        off_next   = off_reg;
        rem_next   = rem_reg;
        lit_next   = lit_reg;
        litb_next  = litb_reg;
        zero_next  = zero_reg;
        acc_next   = acc_reg;
        fill_next  = fill_reg;
        end_next   = end_reg;
        econs_next = econs_reg;
        etot_next  = etot_reg;
        mv_next    = mv_reg && !m_tready;
        md_next    = md_reg;
        ml_next    = ml_reg;
        mu_next    = mu_reg;
        pre        = parse_reg;
        post       = parse_reg;

        unique case (state_reg)
            ST_IN:
            begin
                if (accept)
                begin
                    pre = parse_reg;
                    if (parse_reg.phase <= PH_SBIT)
                    begin
                        pre.cmd   = s_tdata;
                        pre.bits  = 4'd8;
                        cons_next = sum1[COUNT_BITS] ? CountMax : sum1[COUNT_BITS-1:0];
                    end
                    else if (parse_reg.phase == PH_LIT)
                    begin
                        cons_next  = sum1[COUNT_BITS] ? CountMax : sum1[COUNT_BITS-1:0];
                        lit_next   = 1'b1;
                        litb_next  = s_tdata;
                        rem_next   = 9'd1;
                        pre.phase  = PH_BIT0;
                        state_next = ST_RD;
                    end
                    else if (parse_reg.phase == PH_SOFF)
                    begin
                        cons_next  = sum1[COUNT_BITS] ? CountMax : sum1[COUNT_BITS-1:0];
                        off_next   = (s_tdata != 8'd0) ? {4'd0, s_tdata} : 12'h100;
                        lit_next   = 1'b0;
                        rem_next   = parse_reg.mlen;
                        pre.phase  = PH_BIT0;
                        state_next = ST_RD;
                    end
                    else if (parse_reg.phase == PH_LHI)
                    begin
                        held_next = s_tdata;
                        pre.phase = PH_LLO;
                    end
                    else if (parse_reg.phase == PH_LLO)
                    begin
                        if (word == 16'd0)
                        begin
                            econs_next = cons32[FieldWidth-1:0];
                            etot_next  = tot32[FieldWidth-1:0];
                            end_next   = 1'b1;
                            pre        = '0;
                            cons_next  = '0;
                            prod_next  = '0;
                            wp_next    = '0;
                            wrap_next  = 1'b0;
                            off_next   = '0;
                            held_next  = '0;
                            state_next = ST_EMIT;
                        end
                        else
                        begin
                            cons_next = sum2[COUNT_BITS] ? CountMax : sum2[COUNT_BITS-1:0];
                            off_next  = word[15:4];
                            if (s_tdata[3:0] != 4'd0)
                            begin
                                pre.mlen   = {5'd0, s_tdata[3:0]} + 9'd2;
                                rem_next   = {5'd0, s_tdata[3:0]} + 9'd2;
                                lit_next   = 1'b0;
                                pre.phase  = PH_BIT0;
                                state_next = ST_RD;
                            end
                            else
                            begin
                                pre.phase = PH_LLEN;
                            end
                        end
                    end
                    else
                    begin
                        cons_next  = sum1[COUNT_BITS] ? CountMax : sum1[COUNT_BITS-1:0];
                        pre.mlen   = {1'b0, s_tdata} + 9'd1;
                        rem_next   = {1'b0, s_tdata} + 9'd1;
                        lit_next   = 1'b0;
                        pre.phase  = PH_BIT0;
                        state_next = ST_RD;
                    end
                    post       = drain_bits(pre);
                    parse_next = post;
                end
            end
            ST_RD:
            begin
                zero_next  = (off_reg == 12'd0) || (!wrap_reg && (off_ext > wp_reg));
                state_next = ST_WR;
            end
            ST_WR:
            begin
                acc_next[fill_reg[1:0]] = cur_byte;
                fill_next = fill_reg + 3'd1;
                rem_next  = rem_reg - 9'd1;
                wp_next   = wp_reg + AW'(1);
                if (wp_reg == '1)
                begin
                    wrap_next = 1'b1;
                end
                if (prod_reg != CountMax)
                begin
                    prod_next = prod_reg + COUNT_BITS'(1);
                end
                if (fill_reg == 3'(Chunk - 1) || rem_reg == 9'd1)
                begin
                    state_next = ST_EMIT;
                end
                else
                begin
                    state_next = ST_RD;
                end
            end
            ST_EMIT:
            begin
                if (!mv_reg || m_tready)
                begin
                    mv_next = 1'b1;
                    if (end_reg)
                    begin
                        md_next = {5'd0, etot_reg, econs_reg, 3'd0, 32'd0};
                        ml_next = 1'b1;
                        mu_next = 1'b1;
                    end
                    else
                    begin
                        md_next = {5'd0, 48'd0, fill_reg,
                                   acc_reg[3], acc_reg[2], acc_reg[1], acc_reg[0]};
                        ml_next = (rem_reg == 9'd0);
                        mu_next = 1'b0;
                    end
                    for (int i = 0; i < Slots; i++)
                    begin
                        acc_next[i] = 8'd0;
                    end
                    fill_next  = 3'd0;
                    end_next   = 1'b0;
                    state_next = (end_reg || rem_reg == 9'd0) ? ST_IN : ST_RD;
                end
            end
            default:
            begin
                state_next = ST_IN;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IN;
            parse_reg <= '0;
            held_reg  <= '0;
            cons_reg  <= '0;
            prod_reg  <= '0;
            wp_reg    <= '0;
            wrap_reg  <= 1'b0;
            off_reg   <= '0;
            rem_reg   <= '0;
            lit_reg   <= 1'b0;
            zero_reg  <= 1'b0;
            fill_reg  <= '0;
            end_reg   <= 1'b0;
            mv_reg    <= 1'b0;
            for (int i = 0; i < Slots; i++)
            begin
                acc_reg[i] <= 8'd0;
            end
        end
        else
        begin
            state_reg <= state_next;
            parse_reg <= parse_next;
            held_reg  <= held_next;
            cons_reg  <= cons_next;
            prod_reg  <= prod_next;
            wp_reg    <= wp_next;
            wrap_reg  <= wrap_next;
            off_reg   <= off_next;
            rem_reg   <= rem_next;
            lit_reg   <= lit_next;
            zero_reg  <= zero_next;
            fill_reg  <= fill_next;
            end_reg   <= end_next;
            mv_reg    <= mv_next;
            acc_reg   <= acc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        litb_reg  <= litb_next;
        econs_reg <= econs_next;
        etot_reg  <= etot_next;
        md_reg    <= md_next;
        ml_reg    <= ml_next;
        mu_reg    <= mu_next;
    end

endmodule

/* dv/tb_lz_bitflag_decompressor.sv */
`timescale 1ns / 1ps

module tb_lz_bitflag_decompressor;
    import lzbd_pkg::*;

    localparam int  CycleLimit = 1500000;
    localparam int  RandItems  = 237;
    localparam int  QuietItems = 40;
    localparam int  HoldCycles = 400;
    localparam int  DirRows    = 23;
    localparam int  EndRow     = 22;
    localparam logic [23:0] CountMax = 24'hFFFFFF;

    typedef struct packed {
        logic [23:0] total;
        logic [23:0] consumed;
        logic [2:0]  cnt;
        logic [7:0]  b3;
        logic [7:0]  b2;
        logic [7:0]  b1;
        logic [7:0]  b0;
    } chunk_t;

    typedef struct packed {
        chunk_t data;
        logic   last;
        logic   fin;
    } chunk_exp_t;

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [7:0]            s_tdata;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [TdataWidth-1:0] m_tdata;
    logic                  m_tlast;
    logic                  m_tuser;

    lz_bitflag_decompressor DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // decoder image
    localparam int HISTORY_DEPTH_TB = 4096;
    logic [7:0]  hist_ring [HISTORY_DEPTH_TB];
    logic [11:0] wr_ptr;
    logic [7:0]  flag_byte;
    int          flags_left;
    logic [2:0]  phase;
    logic [11:0] copy_off;
    int          copy_len;
    logic [7:0]  word_hi;
    logic [23:0] bytes_in;
    logic [23:0] bytes_out;

    chunk_exp_t  decoded_q [$];
    chunk_exp_t  step_q [$];
    chunk_exp_t  cur_chunk;
    int          cur_fill;

    int          errors;
    int          cycles;
    int          reqs_sent;
    int          chunks_seen;
    int          streams_done;
    bit          quiet;
    bit          want_end;
    int          hold_cnt;
    int          stall_left;

    function automatic logic [23:0] sat_inc(input logic [23:0] a, input int n);
        longint s;
        s = longint'(a) + n;
        return (s > CountMax) ? CountMax : s[23:0];
    endfunction

    task automatic restart_stream();
        for (int i = 0; i < HISTORY_DEPTH_TB; i++)
            hist_ring[i] = 8'd0;
        wr_ptr     = '0;
        flag_byte  = '0;
        flags_left = 0;
        phase      = PH_BIT0;
        copy_off   = '0;
        copy_len   = 0;
        word_hi    = '0;
        bytes_in   = '0;
        bytes_out  = '0;
    endtask

    task automatic push_byte(input logic [7:0] b);
        hist_ring[wr_ptr] = b;
        wr_ptr            = wr_ptr + 12'd1;
        bytes_out         = sat_inc(bytes_out, 1);
        if (cur_fill == 0)
            cur_chunk = '0;
        case (cur_fill)
            0: cur_chunk.data.b0 = b;
            1: cur_chunk.data.b1 = b;
            2: cur_chunk.data.b2 = b;
            default: cur_chunk.data.b3 = b;
        endcase
        cur_fill           = cur_fill + 1;
        cur_chunk.data.cnt = cur_fill[2:0];
        if (cur_fill == 4)
        begin
            step_q.push_back(cur_chunk);
            cur_fill = 0;
        end
    endtask

    task automatic copy_back(input logic [11:0] off, input int len);
        logic [7:0] b;
        for (int i = 0; i < len; i++)
        begin
            b = (off != 12'd0) ? hist_ring[wr_ptr - off] : 8'd0;
            push_byte(b);
        end
        if (cur_fill != 0)
            step_q.push_back(cur_chunk);
        cur_fill = 0;
        phase    = PH_BIT0;
    endtask

    task automatic decode_byte(input logic [7:0] b);
        logic [15:0] word;
        logic        bit_v;
        chunk_exp_t  e;
        step_q.delete();
        cur_fill = 0;
        if (phase <= PH_SBIT)
        begin
            flag_byte  = b;
            flags_left = 8;
            bytes_in   = sat_inc(bytes_in, 1);
        end
        else if (phase == PH_LIT)
        begin
            bytes_in = sat_inc(bytes_in, 1);
            push_byte(b);
            step_q.push_back(cur_chunk);
            cur_fill = 0;
            phase    = PH_BIT0;
        end
        else if (phase == PH_SOFF)
        begin
            bytes_in = sat_inc(bytes_in, 1);
            copy_off = (b != 8'd0) ? {4'd0, b} : 12'h100;
            copy_back(copy_off, copy_len);
        end
        else if (phase == PH_LHI)
        begin
            word_hi = b;
            phase   = PH_LLO;
        end
        else if (phase == PH_LLO)
        begin
            word = {word_hi, b};
            if (word == 16'd0)
            begin
                e               = '0;
                e.last          = 1'b1;
                e.fin           = 1'b1;
                e.data.consumed = bytes_in;
                e.data.total    = sat_inc(bytes_out, 2);
                decoded_q.push_back(e);
                streams_done++;
                restart_stream();
                return;
            end
            bytes_in = sat_inc(bytes_in, 2);
            copy_off = word[15:4];
            if (b[3:0] != 4'd0)
            begin
                copy_len = b[3:0] + 2;
                copy_back(copy_off, copy_len);
            end
            else
                phase = PH_LLEN;
        end
        else
        begin
            bytes_in = sat_inc(bytes_in, 1);
            copy_len = b + 1;
            copy_back(copy_off, copy_len);
        end

        while (phase <= PH_SBIT && flags_left > 0)
        begin
            bit_v      = flag_byte[0];
            flag_byte  = flag_byte >> 1;
            flags_left = flags_left - 1;
            if (phase == PH_BIT0)
                phase = bit_v ? PH_BIT1 : PH_LIT;
            else if (phase == PH_BIT1)
            begin
                copy_len = 0;
                phase    = bit_v ? PH_SBIT : PH_LHI;
            end
            else if (copy_len == 0)
                copy_len = bit_v ? 4 : 2;
            else
            begin
                copy_len = copy_len + bit_v;
                phase    = PH_SOFF;
            end
        end

        if (step_q.size() > 0)
            step_q[step_q.size() - 1].last = 1'b1;
        foreach (step_q[i])
            decoded_q.push_back(step_q[i]);
    endtask

    // mostly well-formed content: short offsets and lengths, occasional end word
    function automatic logic [7:0] pick_byte();
        logic [7:0] v;
        v = 8'($urandom_range(0, 255));
        if (phase == PH_SOFF && $urandom_range(0, 3) == 0)
            v = 8'($urandom_range(1, 16));
        else if (phase == PH_LHI)
        begin
            want_end = ($urandom_range(0, 24) == 0);
            if (want_end || $urandom_range(0, 3) != 0)
                v = want_end ? 8'd0 : 8'($urandom_range(0, 2));
        end
        else if (phase == PH_LLO && want_end)
            v = 8'd0;
        else if (phase == PH_LLEN && $urandom_range(0, 9) != 0)
            v = 8'($urandom_range(0, 15));
        return v;
    endfunction

    task automatic send_req(input logic [7:0] v, input bit typed, input chunk_exp_t t);
        s_tvalid <= 1'b1;
        s_tdata  <= v;
        do
            @(posedge clk);
        while (!s_tready);
        decode_byte(v);
        if (typed)
            decoded_q[decoded_q.size() - 1] = t;
        reqs_sent++;
        @(negedge clk);
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge clk);
        end
    endtask

    always @(negedge clk)
    begin
        if (hold_cnt > 0)
        begin
            hold_cnt--;
            m_tready <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            m_tready <= 1'b0;
        end
        else if (!quiet && $urandom_range(0, 5) == 0)
        begin
            stall_left = $urandom_range(0, 2);
            m_tready <= 1'b0;
        end
        else
            m_tready <= 1'b1;
    end

    always @(posedge clk)
    begin
        chunk_exp_t e;
        if (rst_n && m_tvalid && m_tready)
        begin
            chunks_seen++;
            if (decoded_q.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result: tdata=%h last=%b user=%b",
                             m_tdata, m_tlast, m_tuser);
            end
            else
            begin
                e = decoded_q.pop_front();
                if (m_tdata[82:0] !== e.data || m_tlast !== e.last || m_tuser !== e.fin)
                begin
                    errors++;
                    if (errors <= 10)
                        $display({"mismatch: exp data=%h last=%b user=%b, ",
                                  "got data=%h last=%b user=%b"},
                                 e.data, e.last, e.fin, m_tdata[82:0], m_tlast, m_tuser);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CycleLimit)
        begin
            $display("tb_lz_bitflag_decompressor: done, errors");
            $finish;
        end
    end

    logic [7:0] dir_bytes [DirRows] = '{
        8'h00, 8'h00, 8'hFF, 8'h55, 8'hAA, 8'h01, 8'h80, 8'h7F, 8'hFE,
        8'h0F, 8'h00, 8'h12, 8'h12, 8'h12, 8'h12,
        8'h15, 8'h00, 8'h10, 8'hFF, 8'h00, 8'h03, 8'h00, 8'h00
    };

    initial
    begin
        chunk_exp_t end_exp;
        chunk_exp_t none;
        errors       = 0;
        cycles       = 0;
        reqs_sent    = 0;
        chunks_seen  = 0;
        streams_done = 0;
        quiet        = 1'b0;
        want_end     = 1'b0;
        hold_cnt     = 0;
        stall_left   = 0;
        cur_fill     = 0;
        none         = '0;
        rst_n        = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = 8'd0;
        m_tready     = 1'b0;
        restart_stream();
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // literals, short match reaching before the start, long match with
        // extra length byte, zero-offset match, then the end word
        end_exp               = '0;
        end_exp.last          = 1'b1;
        end_exp.fin           = 1'b1;
        end_exp.data.consumed = 24'd21;
        end_exp.data.total    = 24'd280;
        for (int i = 0; i < DirRows; i++)
            send_req(dir_bytes[i], i == EndRow, (i == EndRow) ? end_exp : none);

        hold_cnt = HoldCycles;
        for (int i = 0; i < RandItems; i++)
        begin
            if (i == RandItems - QuietItems)
                quiet = 1'b1;
            send_req(pick_byte(), 1'b0, none);
        end
        s_tvalid <= 1'b0;

        while (decoded_q.size() > 0)
            @(posedge clk);
        repeat (100) @(posedge clk);

        $display("requests sent %0d, results checked %0d, streams ended %0d",
                 reqs_sent, chunks_seen, streams_done);
        if (errors == 0)
            $display("tb_lz_bitflag_decompressor: done, clean");
        else
            $display("tb_lz_bitflag_decompressor: done, errors");
        $finish;
    end

endmodule
